/* sv/trbc_pkg.sv */
package trbc_pkg;

   localparam int MAX_NODES_DEFAULT = 1024;
   localparam int CSR_DATA_W        = 11;
   localparam int CSR_INDEX_W       = 1;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_CLEAR = 2'd2
   } command_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOMA_TYPE   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHILD_LIMIT = 1'b1;

   localparam logic [7:0]         SOMA_TYPE_RESET   = 8'd1;
   localparam logic [10:0]        CHILD_LIMIT_RESET = 11'd2;
   localparam logic [10:0]        CHILD_MAX         = 11'h7ff;
   localparam logic signed [31:0] PARENT_NONE       = -32'sd1;

   typedef struct packed {
      logic [1:0]         command;
      logic [30:0]        node_id;
      logic signed [31:0] parent_ref;
      logic [7:0]         node_type;
      logic [9:0]         query_index;
   } req_type;

   typedef struct packed {
      logic        is_root;
      logic        is_multifurcation;
      logic        is_soma;
      logic [10:0] child_count;
      logic        index_valid;
      logic        overflowed;
   } rsp_type;

   // one stored table entry
   typedef struct packed {
      logic [30:0]        id;
      logic signed [31:0] parent;
      logic [7:0]         ntype;
   } node_entry_type;

   // per-query outcome handed from the scan unit to the top level
   typedef struct packed {
      logic        is_root;
      logic        is_multifurcation;
      logic        is_soma;
      logic [10:0] child_count;
      logic        index_valid;
   } scan_result_type;

endpackage

/* sv/trbc_node_ram.sv */
module trbc_node_ram #(
   parameter int MAX_NODES = trbc_pkg::MAX_NODES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(MAX_NODES)-1:0]    wr_addr,
   input  trbc_pkg::node_entry_type        wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(MAX_NODES)-1:0]    rd_addr,
   output trbc_pkg::node_entry_type        rd_data
);
   import trbc_pkg::*;

   node_entry_type mem [MAX_NODES];
   node_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/trbc_scan.sv */
module trbc_scan #(
   parameter int MAX_NODES = trbc_pkg::MAX_NODES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start_i,
   input  logic                              start_valid_i,
   input  logic [$clog2(MAX_NODES)-1:0]      start_addr_i,
   input  logic [$clog2(MAX_NODES+1)-1:0]    count_i,
   input  logic [7:0]                        soma_type_i,
   input  logic [10:0]                       child_limit_i,
   input  logic                              out_free_i,
   output logic                              busy_o,
   output logic                              done_o,
   output trbc_pkg::scan_result_type         result_o,
   output logic                              rd_en_o,
   output logic [$clog2(MAX_NODES)-1:0]      rd_addr_o,
   input  trbc_pkg::node_entry_type          rd_data_i
);
   import trbc_pkg::*;

   localparam int AW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_HEAD   = 4'b0010,
      S_SCAN   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      iss_ff, iss_in;
   logic [AW-1:0]      dat_ff, dat_in;
   logic               dv_ff, dv_in;
   logic [AW-1:0]      q_ff, q_in;
   logic               valid_ff, valid_in;
   logic signed [31:0] par_ff, par_in;
   logic [30:0]        myid_ff, myid_in;
   logic               found_ff, found_in;
   logic               shadow_ff, shadow_in;
   logic [10:0]        cnt_ff, cnt_in;
   logic               have_soma_ff, have_soma_in;
   logic               soma_q_ff, soma_q_in;

   logic               id_hit, shadow_hit, child_hit, soma_hit;
   logic [10:0]        children;
   logic               soma_flag;

   // entry compares against the data read in the previous cycle
   assign id_hit     = !par_ff[31] && (par_ff[30:0] == rd_data_i.id);
   assign shadow_hit = (dat_ff > q_ff) && (rd_data_i.id == myid_ff);
   assign child_hit  = !rd_data_i.parent[31] && (rd_data_i.parent[30:0] == myid_ff);
   assign soma_hit   = (rd_data_i.ntype == soma_type_i) && (rd_data_i.parent == PARENT_NONE);

   always_comb begin
      state_in     = state_ff;
      iss_in       = iss_ff;
      dat_in       = dat_ff;
      dv_in        = 1'b0;
      q_in         = q_ff;
      valid_in     = valid_ff;
      par_in       = par_ff;
      myid_in      = myid_ff;
      found_in     = found_ff;
      shadow_in    = shadow_ff;
      cnt_in       = cnt_ff;
      have_soma_in = have_soma_ff;
      soma_q_in    = soma_q_ff;
      rd_en_o      = 1'b0;
      rd_addr_o    = start_addr_i;
      done_o       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start_i) begin
               q_in         = start_addr_i;
               valid_in     = start_valid_i;
               found_in     = 1'b0;
               shadow_in    = 1'b0;
               cnt_in       = '0;
               have_soma_in = 1'b0;
               soma_q_in    = 1'b0;
               if (start_valid_i) begin
                  rd_en_o  = 1'b1;
                  state_in = S_HEAD;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_HEAD: begin
            par_in    = rd_data_i.parent;
            myid_in   = rd_data_i.id;
            rd_en_o   = 1'b1;
            rd_addr_o = '0;
            iss_in    = CW'(1);
            dat_in    = '0;
            dv_in     = 1'b1;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            if (dv_ff) begin
               if (id_hit) found_in = 1'b1;
               if (shadow_hit) shadow_in = 1'b1;
               if (child_hit && (cnt_ff != CHILD_MAX)) cnt_in = cnt_ff + 11'd1;
               if (soma_hit) begin
                  have_soma_in = 1'b1;
                  soma_q_in    = (dat_ff == q_ff);
               end
               if (iss_ff < count_i) begin
                  rd_en_o   = 1'b1;
                  rd_addr_o = iss_ff[AW-1:0];
                  dat_in    = iss_ff[AW-1:0];
                  iss_in    = iss_ff + CW'(1);
                  dv_in     = 1'b1;
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free_i) begin
               done_o   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         dv_ff    <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff       <= iss_in;
      dat_ff       <= dat_in;
      q_ff         <= q_in;
      valid_ff     <= valid_in;
      par_ff       <= par_in;
      myid_ff      <= myid_in;
      found_ff     <= found_in;
      shadow_ff    <= shadow_in;
      cnt_ff       <= cnt_in;
      have_soma_ff <= have_soma_in;
      soma_q_ff    <= soma_q_in;
   end

   assign children  = shadow_ff ? 11'd0 : cnt_ff;
   assign soma_flag = have_soma_ff && soma_q_ff;

   always_comb begin
      result_o = '0;
      if (valid_ff) begin
         result_o.is_root           = (par_ff == PARENT_NONE) || !found_ff;
         result_o.is_soma           = soma_flag;
         result_o.child_count       = children;
         result_o.is_multifurcation = (children > child_limit_i) && !soma_flag;
         result_o.index_valid       = 1'b1;
      end
   end

   assign busy_o = (state_ff != S_IDLE);

   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      start_i |-> (state_ff == S_IDLE))
      else $error("query started while scan busy");

   a_dv_scan : assert property (@(posedge clock) disable iff (reset)
      dv_ff |-> (state_ff == S_SCAN))
      else $error("read data pending outside scan");

   a_iss_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (iss_ff <= count_i))
      else $error("scan issued past loaded count");

   a_done_free : assert property (@(posedge clock) disable iff (reset)
      done_o |=> (state_ff == S_IDLE))
      else $error("scan did not return to idle after finish");

endmodule

/* sv/tree_root_and_branch_check.sv */
// Tree node table with root and branch queries. Nodes (id, parent id, type) are loaded one per
// transfer into a single-port-read table memory of MAX_NODES entries; a clear transfer empties
// the table by zeroing the fill count, so no clearing pass is ever run. Loads and clears give
// no result. A query scans the table one entry per cycle through the memory read port: an
// in-range query reads the asked node, then each stored node in turn, then drains the last read
// and finishes by putting its result in the output register; an out-of-range query goes straight
// to the finish step. The input stalls for the whole scan and takes the next transfer once the
// result is registered; the finish step also waits while an earlier result is still stalled.
// Results sit in an output register, so loads and clears are taken while a result waits. Each
// query reports whether the node is a root, its child count (saturating at 2047), whether it
// is the soma (the last stored node of the soma type with parent id minus one) and whether it
// is a multifurcation; a load into a full table is dropped and flagged until the next clear.
module tree_root_and_branch_check #(
   parameter int MAX_NODES = trbc_pkg::MAX_NODES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  trbc_pkg::req_type                   req_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output trbc_pkg::rsp_type                   rsp_data,
   // configuration writes
   input  logic                                csr_wr_en,
   input  logic [trbc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [trbc_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import trbc_pkg::*;

   localparam int AW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int QW = (CW > 10) ? CW : 10;

   // configuration registers
   logic [7:0]      soma_type_ff, soma_type_in;
   logic [10:0]     child_limit_ff, child_limit_in;

   // table fill state
   logic [CW-1:0]   count_ff, count_in;
   logic            overflow_ff, overflow_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic            req_xfer;
   logic            is_load, is_query, is_clear;
   logic            table_full;
   logic [QW-1:0]   q_ext;
   logic            idx_valid;

   logic            ram_wr_en;
   node_entry_type  ram_wr_data;
   logic            ram_rd_en;
   logic [AW-1:0]   ram_rd_addr;
   node_entry_type  ram_rd_data;

   logic            scan_busy;
   logic            scan_done;
   logic            out_free;
   scan_result_type scan_result;

   // no new transfer while a query scan is running
   assign req_stall = scan_busy;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      is_load  = 1'b0;
      is_query = 1'b0;
      is_clear = 1'b0;
      unique case (req_data.command)
         CMD_LOAD:  is_load  = 1'b1;
         CMD_QUERY: is_query = 1'b1;
         CMD_CLEAR: is_clear = 1'b1;
         default:   ; // unused command code: ignored
      endcase
   end

   assign table_full = (count_ff == CW'(MAX_NODES));

   // index check in a width that holds both the index and the count
   assign q_ext     = QW'(req_data.query_index);
   assign idx_valid = q_ext < QW'(count_ff);

   // config register writes
   always_comb begin
      soma_type_in   = soma_type_ff;
      child_limit_in = child_limit_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SOMA_TYPE:   soma_type_in   = csr_wr_data[7:0];
            CSR_CHILD_LIMIT: child_limit_in = csr_wr_data[10:0];
            default:         ;
         endcase
      end
   end

   // loads append at the fill count, a full table drops the load and flags it
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      ram_wr_en   = 1'b0;
      if (req_xfer && is_load) begin
         if (table_full) begin
            overflow_in = 1'b1;
         end else begin
            ram_wr_en = 1'b1;
            count_in  = count_ff + CW'(1);
         end
      end else if (req_xfer && is_clear) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end
   end

   assign ram_wr_data.id     = req_data.node_id;
   assign ram_wr_data.parent = req_data.parent_ref;
   assign ram_wr_data.ntype  = req_data.node_type;

   // output register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (scan_done) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in.is_root           = scan_result.is_root;
         rsp_data_in.is_multifurcation = scan_result.is_multifurcation;
         rsp_data_in.is_soma           = scan_result.is_soma;
         rsp_data_in.child_count       = scan_result.child_count;
         rsp_data_in.index_valid       = scan_result.index_valid;
         rsp_data_in.overflowed        = overflow_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         soma_type_ff   <= SOMA_TYPE_RESET;
         child_limit_ff <= CHILD_LIMIT_RESET;
         count_ff       <= '0;
         overflow_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         soma_type_ff   <= soma_type_in;
         child_limit_ff <= child_limit_in;
         count_ff       <= count_in;
         overflow_ff    <= overflow_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   trbc_node_ram #(
      .MAX_NODES (MAX_NODES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // query scan sequencer, one table entry per cycle
   trbc_scan #(
      .MAX_NODES (MAX_NODES)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .start_i       (req_xfer && is_query),
      .start_valid_i (idx_valid),
      .start_addr_i  (q_ext[AW-1:0]),
      .count_i       (count_ff),
      .soma_type_i   (soma_type_ff),
      .child_limit_i (child_limit_ff),
      .out_free_i    (out_free),
      .busy_o        (scan_busy),
      .done_o        (scan_done),
      .result_o      (scan_result),
      .rd_en_o       (ram_rd_en),
      .rd_addr_o     (ram_rd_addr),
      .rd_data_i     (ram_rd_data)
   );

endmodule
